// File: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: rtl/slins_pkg.sv
package slins_pkg;

    localparam int DEPTH    = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 30;

    localparam logic [VAL_W-1:0] VALUE_LIMIT = VAL_W'(1000000000);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = 1 + VAL_W + 1 + CNT_W + VAL_W + VAL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;       // latch the incoming request
        logic idx_top;   // index <= count - 1
        logic idx_zero;  // index <= 0
        logic idx_dec;
        logic idx_inc;
        logic rd_en;     // read the store at the index
        logic wr_en;
        logic wr_zero;   // write address 0 instead of index + 1
        logic wr_val;    // write the request value instead of the read data
        logic commit;    // bump count, update min and max
        logic out_load;
        logic out_elem;  // dump element result instead of a response
        logic out_acc;
    } slins_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_dump;
        logic val_bad;
        logic full;
        logic empty;
        logic rd_gt;
        logic idx_zero;
        logic idx_last;
        logic out_free;
    } slins_sts_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DECODE   = 9'b000000010,
        ST_INS_RD   = 9'b000000100,
        ST_INS_CMP  = 9'b000001000,
        ST_INS_PUT  = 9'b000010000,
        ST_RESP_OK  = 9'b000100000,
        ST_RESP_NO  = 9'b001000000,
        ST_DUMP_RD  = 9'b010000000,
        ST_DUMP_OUT = 9'b100000000
    } slins_state_t;

endpackage

// File: rtl/slins_ctrl.sv
module slins_ctrl
    import slins_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  slins_sts_t sts,
    output slins_cmd_t cmd
);

    slins_state_t state_reg;
    slins_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.req_dump)
                begin
                    if (sts.empty)
                    begin
                        state_next = ST_RESP_NO;
                    end
                    else
                    begin
                        cmd.idx_zero = 1'b1;
                        state_next   = ST_DUMP_RD;
                    end
                end
                else if (sts.val_bad || sts.full)
                begin
                    state_next = ST_RESP_NO;
                end
                else if (sts.empty)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_zero = 1'b1;
                    cmd.wr_val  = 1'b1;
                    cmd.commit  = 1'b1;
                    state_next  = ST_RESP_OK;
                end
                else
                begin
                    cmd.idx_top = 1'b1;
                    state_next  = ST_INS_RD;
                end
            end
            ST_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt)
                begin
                    // shift the larger entry up one slot
                    if (sts.idx_zero)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = ST_INS_RD;
                    end
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_RESP_OK;
                end
            end
            ST_INS_PUT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_zero = 1'b1;
                cmd.wr_val  = 1'b1;
                cmd.commit  = 1'b1;
                state_next  = ST_RESP_OK;
            end
            ST_RESP_OK:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_acc  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP_NO:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_elem = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/slins_dp.sv
module slins_dp
    import slins_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_req,
    input  logic [VAL_W-1:0]       in_value,
    input  slins_cmd_t             cmd,
    output slins_sts_t             sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic [VAL_W-1:0] mem [DEPTH];

    logic                   req_reg;
    logic [VAL_W-1:0]       value_reg;
    logic [VAL_W-1:0]       rd_data_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [VAL_W-1:0]       min_reg;
    logic [VAL_W-1:0]       min_next;
    logic [VAL_W-1:0]       max_reg;
    logic [VAL_W-1:0]       max_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;

    logic [CNT_W-1:0]       cnt_m1;
    logic [IDX_W-1:0]       wr_addr;
    logic [VAL_W-1:0]       wr_data;
    logic                   empty;
    logic                   idx_last;
    logic [VAL_W-1:0]       out_elem_val;
    logic [OUT_TDATA_W-1:0] out_data_next;

    assign cnt_m1   = count_reg - 1'b1;
    assign empty    = (count_reg == '0);
    assign idx_last = (CNT_W'(idx_reg) == cnt_m1);
    assign wr_addr  = cmd.wr_zero ? '0 : idx_reg + 1'b1;
    assign wr_data  = cmd.wr_val ? value_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            req_reg   <= in_req;
            value_reg <= in_value;
        end
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= cmd.out_elem ? idx_last : 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_top)
        begin
            idx_next = cnt_m1[IDX_W-1:0];
        end
        else if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (cmd.commit)
        begin
            count_next = count_reg + 1'b1;
            if (value_reg < min_reg)
            begin
                min_next = value_reg;
            end
            if (value_reg > max_reg)
            begin
                max_next = value_reg;
            end
        end
    end

    assign out_elem_val  = cmd.out_elem ? rd_data_reg : '0;
    assign out_data_next = {{OUT_PAD_W{1'b0}},
                            (empty ? '0 : max_reg),
                            (empty ? '0 : min_reg),
                            count_reg,
                            empty,
                            out_elem_val,
                            cmd.out_acc};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            min_reg       <= VALUE_LIMIT;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.req_dump = (req_reg == REQ_DUMP);
    assign sts.val_bad  = (value_reg > VALUE_LIMIT);
    assign sts.full     = (count_reg == CNT_W'(DEPTH));
    assign sts.empty    = empty;
    assign sts.rd_gt    = (rd_data_reg > value_reg);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.idx_last = idx_last;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/sorted_list_insert_top.sv
// Sorted list store: keeps up to DEPTH values (0 to 1e9) in ascending order.
// Input stream: s_tuser selects the request (0 insert, 1 dump), s_tdata[29:0]
// carries the value to insert. A value above 1e9, or an insert into a full
// store, is refused and reported with accepted = 0.
// Output stream: one result per insert; one result per stored entry on a
// dump, tlast on the final one; a dump of an empty store gives one result
// with is_empty set. Every result carries count, minimum and maximum.
// Timing: a request is taken only when the controller is idle. An insert
// walks down from the top entry on the single store port, reading and
// comparing one entry at a time and shifting each entry that is larger
// than the new value up one slot; it then writes the new value above the
// first entry that is not larger, or at address 0 when every stored entry
// is larger. An insert into an empty store writes the value at address 0
// directly; a refused insert and a dump of an empty store go straight to
// the response. A dump handles each entry in turn (read, then load).
// Reset empties the store and clears the count; the store contents need
// no clearing pass. When the receiver stalls, the output register holds
// its result and the controller waits before loading the next one, while
// the next request may still be accepted once the current one is done.
`include "assert_macros.svh"

module sorted_list_insert_top
    import slins_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[29:0], zero pad
    input  logic                   s_tuser,   // req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // accepted, element[30:1], is_empty, entry_count[37:32],
    // min_value[67:38], max_value[97:68], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    slins_cmd_t cmd;
    slins_sts_t sts;

    slins_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slins_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_req   (s_tuser),
        .in_value (s_tdata[VAL_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_IMPLIES(a_commit_not_full, clk, rst_n, cmd.commit, !sts.full, "commit into full store")
    `ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.out_load, sts.out_free, "result overwritten")
    `ASSERT_IMPLIES(a_port_excl, clk, rst_n, cmd.rd_en, !cmd.wr_en, "store read and write clash")
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "accepted twice")

endmodule
